### rtl/core/bet_pkg.sv
package bet_pkg;

	// Default table size
	localparam int unsigned ENTRY_COUNT_DEF = 32;

	localparam int unsigned ACTION_W = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned DATA_W   = 32;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_INSERT       = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOOKUP_NAME  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_LOOKUP_VALUE = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESOLVE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic start;   // capture the transaction, rewind the scan
		logic scan;    // issue reads and compare slots
		logic finish;  // commit insert, load result register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic hit;       // compared slot matched
		logic last;      // last slot compared this cycle
		logic out_free;  // result register can take a new result
	} dp_sts_t;

endpackage

### rtl/core/bet_if.sv
// Input transaction channel
interface bet_in_if;
	logic                                valid;
	logic                                ready;
	logic [bet_pkg::ACTION_W-1:0]        action;
	logic [bet_pkg::DATA_W-1:0]          name_hash;
	logic signed [bet_pkg::DATA_W-1:0]   entry_value;
	logic signed [bet_pkg::DATA_W-1:0]   default_value;

	modport source (output valid, output action, output name_hash, output entry_value,
		output default_value, input ready);
	modport sink (input valid, input action, input name_hash, input entry_value,
		input default_value, output ready);
endinterface

// Result transaction channel
interface bet_out_if;
	logic                                valid;
	logic                                ready;
	logic [bet_pkg::STATUS_W-1:0]        status;
	logic signed [bet_pkg::DATA_W-1:0]   result_value;
	logic [bet_pkg::DATA_W-1:0]          result_hash;

	modport source (output valid, output status, output result_value, output result_hash,
		input ready);
	modport sink (input valid, input status, input result_value, input result_hash,
		output ready);
endinterface

### rtl/core/bet_ctrl.sv
module bet_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output bet_pkg::dp_cmd_t cmd,
	input  bet_pkg::dp_sts_t sts
);
	import bet_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.hit || sts.last) state_d = S_RESOLVE;
			end
			S_RESOLVE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
			end
			S_RESOLVE: begin
				cmd.finish = sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

### rtl/core/bet_datapath.sv
module bet_datapath #(
	parameter int unsigned ENTRY_COUNT = bet_pkg::ENTRY_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bet_pkg::dp_cmd_t                   cmd,
	output bet_pkg::dp_sts_t                   sts,
	input  logic [bet_pkg::ACTION_W-1:0]       action,
	input  logic [bet_pkg::DATA_W-1:0]         name_hash,
	input  logic signed [bet_pkg::DATA_W-1:0]  entry_value,
	input  logic signed [bet_pkg::DATA_W-1:0]  default_value,
	bet_out_if.source                          out_ch
);
	import bet_pkg::*;

	localparam int unsigned IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

	// Slot storage; vld_q marks written slots, others read as zero
	logic [DATA_W-1:0] hash_mem [ENTRY_COUNT];
	logic [DATA_W-1:0] val_mem  [ENTRY_COUNT];
	logic [ENTRY_COUNT-1:0] vld_q;

	// Captured transaction
	logic [ACTION_W-1:0] action_q;
	logic [DATA_W-1:0]   hash_q;
	logic [DATA_W-1:0]   value_q;
	logic [DATA_W-1:0]   dflt_q;

	// Scan address and read stage
	logic [IDX_W-1:0]  addr_q;
	logic              issue_done_q;
	logic              rd_en;
	logic              rd_fire_s1;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic [DATA_W-1:0] rd_hash_s1;
	logic [DATA_W-1:0] rd_val_s1;

	// Compare results
	logic [DATA_W-1:0] eff_hash;
	logic [DATA_W-1:0] eff_val;
	logic              match;
	logic              cmp_en;
	logic              found_q;
	logic              empty_found_q;
	logic [IDX_W-1:0]  empty_idx_q;
	logic [DATA_W-1:0] res_hash_q;
	logic [DATA_W-1:0] res_val_q;

	// Resolved result
	logic [STATUS_W-1:0] status_d;
	logic [DATA_W-1:0]   rvalue_d;
	logic [DATA_W-1:0]   rhash_d;
	logic                do_write;

	// Result register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [DATA_W-1:0]   rvalue_q;
	logic [DATA_W-1:0]   rhash_q;

	// Transaction capture
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			action_q <= action;
			hash_q   <= name_hash;
			value_q  <= entry_value;
			dflt_q   <= default_value;
		end
	end

	// Scan address counter
	assign rd_en = cmd.scan && !issue_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			issue_done_q <= 1'b0;
			rd_fire_s1   <= 1'b0;
			rd_vld_s1    <= 1'b0;
		end else begin
			rd_fire_s1 <= rd_en;
			if (rd_en) rd_vld_s1 <= vld_q[addr_q];
			if (cmd.start) begin
				addr_q       <= '0;
				issue_done_q <= 1'b0;
			end else if (rd_en) begin
				if (addr_q == LAST_IDX) begin
					issue_done_q <= 1'b1;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
		end
	end

	// Memory read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_hash_s1 <= hash_mem[addr_q];
			rd_val_s1  <= val_mem[addr_q];
			rd_idx_s1  <= addr_q;
		end
	end

	// Memory write port
	always_ff @(posedge clk) begin
		if (do_write) begin
			hash_mem[empty_idx_q] <= hash_q;
			val_mem[empty_idx_q]  <= value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (do_write) begin
			vld_q[empty_idx_q] <= 1'b1;
		end
	end

	// Slot compare
	assign eff_hash = rd_vld_s1 ? rd_hash_s1 : '0;
	assign eff_val  = rd_vld_s1 ? rd_val_s1 : '0;
	assign cmp_en   = cmd.scan && rd_fire_s1;

	always_comb begin
		unique case (action_q)
			ACT_INSERT,
			ACT_LOOKUP_NAME:  match = (eff_hash == hash_q);
			ACT_LOOKUP_VALUE: match = (eff_val == value_q);
			default:          match = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q       <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (cmd.start) begin
			found_q       <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (cmp_en) begin
			if (match) found_q <= 1'b1;
			if (eff_hash == '0) empty_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			if (match) begin
				res_hash_q <= eff_hash;
				res_val_q  <= eff_val;
			end
			if (!empty_found_q && eff_hash == '0) empty_idx_q <= rd_idx_s1;
		end
	end

	assign sts.hit      = cmp_en && match;
	assign sts.last     = cmp_en && (rd_idx_s1 == LAST_IDX);
	assign sts.out_free = !out_valid_q || out_ch.ready;

	// Resolve the outcome
	always_comb begin
		status_d = STAT_NOT_FOUND;
		rvalue_d = '0;
		rhash_d  = '0;
		do_write = 1'b0;
		unique case (action_q)
			ACT_INSERT: begin
				if (found_q) begin
					status_d = STAT_DUPLICATE;
				end else if (empty_found_q) begin
					status_d = STAT_OK;
					do_write = cmd.finish;
				end else begin
					status_d = STAT_FULL;
				end
			end
			ACT_LOOKUP_NAME: begin
				status_d = found_q ? STAT_OK : STAT_NOT_FOUND;
				rvalue_d = found_q ? res_val_q : dflt_q;
			end
			ACT_LOOKUP_VALUE: begin
				status_d = found_q ? STAT_OK : STAT_NOT_FOUND;
				rhash_d  = found_q ? res_hash_q : '0;
			end
			default: ;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= status_d;
			rvalue_q <= rvalue_d;
			rhash_q  <= rhash_d;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = status_q;
	assign out_ch.result_value = rvalue_q;
	assign out_ch.result_hash  = rhash_q;

endmodule

### rtl/core/bidirectional_enum_table_top.sv
// Small associative table of ENTRY_COUNT slots, each holding a 32-bit name hash and a
// signed 32-bit value; a zero hash marks an empty slot and every slot is empty after
// reset. Insert fills the lowest empty slot (or reports a duplicate name or a full
// table), name lookup returns the lowest matching slot's value or the given default,
// and value lookup returns the lowest matching slot's hash or zero. Empty slots match
// like any other. The slots are read from memory one slot per cycle, and each read slot
// is compared in the registered stage behind the read; the scan stops at the first
// matching slot or after the last slot. One transaction is in flight at a time; the
// result register holds a result until it is taken, a finished scan waits while it is
// still full, and the next transaction is accepted once its result has been loaded.
module bidirectional_enum_table_top #(
	parameter int unsigned ENTRY_COUNT = bet_pkg::ENTRY_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bet_in_if.sink    in_ch,
	bet_out_if.source out_ch
);
	import bet_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	bet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	bet_datapath #(
		.ENTRY_COUNT (ENTRY_COUNT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (in_ch.action),
		.name_hash     (in_ch.name_hash),
		.entry_value   (in_ch.entry_value),
		.default_value (in_ch.default_value),
		.out_ch        (out_ch)
	);

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

import bet_pkg::*;

// Action code with no operation behind it
localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

typedef logic [DATA_W-1:0] word_t;

typedef struct {
	logic [STATUS_W-1:0] status;
	word_t               value;
	word_t               hash;
} lookup_result_t;

// Shadow copy of the table plus the queue of results it predicts
class table_scoreboard;
	word_t          slot_hash  [ENTRY_COUNT_DEF];
	word_t          slot_value [ENTRY_COUNT_DEF];
	lookup_result_t expected_results[$];
	int unsigned    fail_count;

	function new();
		foreach (slot_hash[i]) begin
			slot_hash[i]  = '0;
			slot_value[i] = '0;
		end
		fail_count = 0;
	endfunction

	function bit find_hash(word_t h, output int unsigned idx);
		idx = 0;
		for (int unsigned i = 0; i < ENTRY_COUNT_DEF; i++) begin
			if (slot_hash[i] == h) begin
				idx = i;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function bit find_value(word_t v, output int unsigned idx);
		idx = 0;
		for (int unsigned i = 0; i < ENTRY_COUNT_DEF; i++) begin
			if (slot_value[i] == v) begin
				idx = i;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function int pending();
		return expected_results.size();
	endfunction

	// Accepted input: update the shadow table and queue the result it causes
	function void note_input(logic [ACTION_W-1:0] act, word_t h, word_t v, word_t d);
		lookup_result_t res;
		int unsigned    idx;
		res.status = STAT_NOT_FOUND;
		res.value  = '0;
		res.hash   = '0;
		case (act)
			ACT_INSERT: begin
				// empty slots hold hash zero, so a zero name is a duplicate while any is free
				if (find_hash(h, idx)) begin
					res.status = STAT_DUPLICATE;
				end else if (!find_hash('0, idx)) begin
					res.status = STAT_FULL;
				end else begin
					slot_hash[idx]  = h;
					slot_value[idx] = v;
					res.status      = STAT_OK;
				end
			end
			ACT_LOOKUP_NAME: begin
				if (find_hash(h, idx)) begin
					res.status = STAT_OK;
					res.value  = slot_value[idx];
				end else begin
					res.value  = d;
				end
			end
			ACT_LOOKUP_VALUE: begin
				if (find_value(v, idx)) begin
					res.status = STAT_OK;
					res.hash   = slot_hash[idx];
				end
			end
			default: begin
			end
		endcase
		expected_results.push_back(res);
	endfunction

	task report(string msg);
		fail_count++;
		if (fail_count <= 100)
			$display("%0t ns mismatch: %s", $time, msg);
	endtask

	// Accepted result: compare against the oldest prediction
	task check_result(logic [STATUS_W-1:0] st, word_t rv, word_t rh);
		lookup_result_t exp_res;
		if (expected_results.size() == 0) begin
			report($sformatf("result with nothing pending: status %0d", st));
			return;
		end
		exp_res = expected_results.pop_front();
		if (st !== exp_res.status)
			report($sformatf("status %0d, predicted %0d", st, exp_res.status));
		if (rv !== exp_res.value)
			report($sformatf("result_value %h, predicted %h", rv, exp_res.value));
		if (rh !== exp_res.hash)
			report($sformatf("result_hash %h, predicted %h", rh, exp_res.hash));
	endtask
endclass

module tb_top;
	localparam int unsigned RANDOM_ITEMS = 2000;
	localparam int unsigned POOL_SIZE    = 48;
	localparam int unsigned HOLD_CYCLES  = 400;

	logic clk;
	logic arst_n;

	bet_in_if  in_ch();
	bet_out_if out_ch();

	bidirectional_enum_table_top #(
		.ENTRY_COUNT(ENTRY_COUNT_DEF)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	table_scoreboard sb;
	bit              quiet_mode;
	bit              hold_request;
	word_t           name_pool  [POOL_SIZE];
	word_t           value_pool [POOL_SIZE];

	// Clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic word_t pick_name();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return name_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (r < 65)
			return '0;
		return $urandom();
	endfunction

	function automatic word_t pick_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return value_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (r < 70)
			return '0;
		return $urandom();
	endfunction

	// Offer one transaction and hold it until accepted; leaves valid high
	task automatic send_item(input logic [ACTION_W-1:0] act, input word_t h, input word_t v,
		input word_t d);
		in_ch.valid         <= 1'b1;
		in_ch.action        <= act;
		in_ch.name_hash     <= h;
		in_ch.entry_value   <= v;
		in_ch.default_value <= d;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(act, h, v, d);
		@(negedge clk);
	endtask

	// Random idle before the next transaction
	task automatic send_gap();
		if (!quiet_mode && $urandom_range(0, 99) < 30) begin
			in_ch.valid <= 1'b0;
			repeat (pick_gap()) @(negedge clk);
		end
	endtask

	task automatic send_op(input logic [ACTION_W-1:0] act, input word_t h, input word_t v,
		input word_t d);
		send_gap();
		send_item(act, h, v, d);
	endtask

	task automatic send_random_op();
		int unsigned         r;
		logic [ACTION_W-1:0] act;
		r = $urandom_range(0, 99);
		if (r < 5)
			act = ACT_INSERT;
		else if (r < 48)
			act = ACT_LOOKUP_NAME;
		else if (r < 95)
			act = ACT_LOOKUP_VALUE;
		else
			act = ACT_UNUSED;
		send_op(act, pick_name(), pick_value(), $urandom());
	endtask

	// Result side: random back-pressure and one long hold-off
	initial begin : result_sink
		int unsigned hold_left;
		int unsigned stall_left;
		hold_left  = 0;
		stall_left = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else if (stall_left != 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				if (!quiet_mode && $urandom_range(0, 99) < 30)
					stall_left = pick_gap();
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.status, out_ch.result_value, out_ch.result_hash);
	end

	// Run limit
	initial begin
		#10ms;
		$display("status: fail");
		$finish;
	end

	// Stimulus
	initial begin
		sb           = new();
		quiet_mode   = 1'b0;
		hold_request = 1'b0;
		arst_n       = 1'b0;
		in_ch.valid         = 1'b0;
		in_ch.action        = ACT_INSERT;
		in_ch.name_hash     = '0;
		in_ch.entry_value   = '0;
		in_ch.default_value = '0;

		// Name pool: extremes first, the rest random nonzero
		name_pool[0] = 32'hFFFF_FFFF;
		name_pool[1] = 32'h8000_0000;
		name_pool[2] = 32'h0000_0001;
		name_pool[3] = 32'h7FFF_FFFF;
		for (int i = 4; i < POOL_SIZE; i++) begin
			do name_pool[i] = $urandom(); while (name_pool[i] == '0);
		end
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'hFFFF_FFFF;
		value_pool[3] = 32'h0000_0000;
		for (int i = 4; i < POOL_SIZE; i++)
			value_pool[i] = $urandom();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty slots match hash zero and value zero
		send_op(ACT_LOOKUP_NAME, 32'h0, 32'h0, 32'h7FFF_FFFF);
		send_op(ACT_LOOKUP_VALUE, 32'h0, 32'h0, 32'h0);
		send_op(ACT_LOOKUP_NAME, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
		send_op(ACT_LOOKUP_VALUE, 32'h0, 32'h7FFF_FFFF, 32'h0);
		// zero name while slots are free: duplicate
		send_op(ACT_INSERT, 32'h0, 32'h5, 32'h0);
		send_op(ACT_INSERT, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		send_op(ACT_INSERT, 32'hFFFF_FFFF, 32'h1, 32'h0);
		send_op(ACT_INSERT, 32'h1, 32'h7FFF_FFFF, 32'h0);
		send_op(ACT_INSERT, 32'h8000_0000, 32'h0, 32'h0);
		send_op(ACT_LOOKUP_NAME, 32'hFFFF_FFFF, 32'h0, 32'h1234_5678);
		send_op(ACT_LOOKUP_NAME, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
		send_op(ACT_LOOKUP_VALUE, 32'h0, 32'h8000_0000, 32'h0);
		// value zero now hits a filled slot ahead of the first empty one
		send_op(ACT_LOOKUP_VALUE, 32'h0, 32'h0, 32'h0);
		send_op(ACT_LOOKUP_VALUE, 32'h0, 32'h7FFF_FFFF, 32'h0);
		send_op(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(ACT_LOOKUP_NAME, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// Random: the table fills up part way through and stays full
		for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 250 == 0)
				quiet_mode = ($urandom_range(0, 2) == 0);
			if (i == 400)
				hold_request = 1'b1;
			if (i == 1200) begin
				// let the block drain completely before going on
				in_ch.valid <= 1'b0;
				@(negedge clk);
				while (sb.pending() != 0) @(negedge clk);
			end
			send_random_op();
		end

		// Drain
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
		repeat (ENTRY_COUNT_DEF + 8) @(negedge clk);
		if (sb.fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
